// File: hdl/column_mean_and_detail_profile_unit_macros.svh
// Assertion macros shared by the checker files of the column profile unit.
`ifndef COLUMN_MEAN_AND_DETAIL_PROFILE_UNIT_MACROS_SVH
`define COLUMN_MEAN_AND_DETAIL_PROFILE_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CMDP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("column profile check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define CMDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("column profile check failed in the following cycle");

`endif

// File: hdl/cmdp_pkg.sv
// Shared types and constants of the column profile unit.
package cmdp_pkg;

    // Fixed field and register widths.
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 1;
    localparam int POS_W   = 12;
    localparam int SUM_W   = 28;
    localparam int PIX_W   = 16;
    localparam int COL_W   = 12;
    localparam int RES_W   = 24;

    // Reset geometry.
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 13'd1024;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_row;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

// File: hdl/cmdp_ram.sv
// Generic simple dual-port RAM with registered read data.
module cmdp_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cmdp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module cmdp_div #(
    parameter int N     = 36,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N-1:0]     i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [N-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     r_work;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        rem_sh  = {r_rem, r_work[N-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = (rem_sh >= {1'b0, r_dvs});
    end

    // The work register shifts the dividend out and the quotient in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_cnt  <= CNT_W'(N);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_work <= {r_work[N-2:0], ge};
            r_rem  <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_work;

endmodule

// File: hdl/cmdp_ctrl.sv
// Controller state machine that sequences each pixel through the datapath.
module cmdp_ctrl import cmdp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pix_valid,
    output logic    o_pix_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // State register and the registered input ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pix_valid && r_in_ready) begin
                        r_state    <= ST_UPDATE;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_UPDATE: begin
                    if (i_status.last_row) begin
                        r_state <= ST_DIVIDE;
                    end else begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                ST_DIVIDE: begin
                    if (!i_status.div_busy) begin
                        r_state <= ST_DELIVER;
                    end
                end
                ST_DELIVER: begin
                    if (i_status.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    // Commands decoded from the state, the input handshake and the status.
    always_comb begin
        o_cmd.accept    = i_pix_valid && r_in_ready;
        o_cmd.update    = (r_state == ST_UPDATE);
        o_cmd.div_start = (r_state == ST_UPDATE) && i_status.last_row;
        o_cmd.load_out  = (r_state == ST_DELIVER) && i_status.out_free;
    end

    assign o_pix_ready = r_in_ready;

endmodule

// File: hdl/cmdp_datapath.sv
// Datapath: geometry registers, position counters, column memory, dividers, result register.
module cmdp_datapath import cmdp_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PIXEL_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_res_ready,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_res_valid,
    output logic [COL_W-1:0] o_column,
    output logic [RES_W-1:0] o_column_mean,
    output logic [RES_W-1:0] o_column_detail,
    output logic             o_last_column
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MEM_W = 2 * SUM_W + PIXEL_BITS;
    localparam int DIV_N = SUM_W + FRACTION_BITS;
    // Wide enough to compare the 13-bit registers against limits up to 131071.
    localparam int LIM_W = CFG_W + 4;

    logic [CFG_W-1:0]      r_width;
    logic [CFG_W-1:0]      r_height;
    logic [POS_W-1:0]      r_xpos;
    logic [POS_W-1:0]      r_ypos;

    logic [PIXEL_BITS-1:0] r_pixel;
    logic [POS_W-1:0]      r_col;
    logic                  r_first_row;
    logic                  r_last_row;
    logic                  r_last_col;

    logic                  r_res_valid;
    logic [COL_W-1:0]      r_column;
    logic [RES_W-1:0]      r_mean;
    logic [RES_W-1:0]      r_detail;
    logic                  r_last;

    logic [CFG_W-1:0]      w_eff;
    logic [CFG_W-1:0]      h_eff;
    logic [CFG_W-1:0]      steps;
    logic [CFG_W-1:0]      x_eff;
    logic [CFG_W-1:0]      y_eff;
    logic [CFG_W-1:0]      x_inc;
    logic [CFG_W-1:0]      y_inc;
    logic [POS_W-1:0]      n_xpos;
    logic [POS_W-1:0]      n_ypos;

    logic [MEM_W-1:0]      rd_data;
    logic [MEM_W-1:0]      wr_data;
    logic [SUM_W-1:0]      rd_mean;
    logic [SUM_W-1:0]      rd_detail;
    logic [PIXEL_BITS-1:0] rd_prev;
    logic [PIXEL_BITS-1:0] diff;
    logic [SUM_W-1:0]      new_mean;
    logic [SUM_W-1:0]      new_detail;

    logic                  busy_mean;
    logic                  busy_detail;
    logic [DIV_N-1:0]      quo_mean;
    logic [DIV_N-1:0]      quo_detail;
    logic [DIV_N-1:0]      dividend_mean;
    logic [DIV_N-1:0]      dividend_detail;
    logic                  out_free;

    // Effective geometry: zero counts as one, oversize is clamped.
    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (LIM_W'(r_width) > LIM_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (LIM_W'(r_height) > LIM_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        steps = (h_eff > CFG_W'(1)) ? h_eff - CFG_W'(1) : CFG_W'(1);
    end

    // Current position, clamped into the frame, and the next position.
    always_comb begin
        x_eff = (CFG_W'(r_xpos) >= w_eff) ? w_eff - CFG_W'(1) : CFG_W'(r_xpos);
        y_eff = (CFG_W'(r_ypos) >= h_eff) ? h_eff - CFG_W'(1) : CFG_W'(r_ypos);
        x_inc = x_eff + CFG_W'(1);
        y_inc = y_eff + CFG_W'(1);
        if (x_inc >= w_eff) begin
            n_xpos = '0;
            n_ypos = (y_inc >= h_eff) ? '0 : POS_W'(y_inc);
        end else begin
            n_xpos = POS_W'(x_inc);
            n_ypos = r_ypos;
        end
    end

    // Geometry registers and position counters; any register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_SIZE_RESET;
            r_height <= CFG_SIZE_RESET;
            r_xpos   <= '0;
            r_ypos   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
            r_xpos <= '0;
            r_ypos <= '0;
        end else if (i_cmd.accept) begin
            r_xpos <= n_xpos;
            r_ypos <= n_ypos;
        end
    end

    // Capture the pixel and its place in the frame at each input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pixel     <= PIXEL_BITS'(i_pixel);
            r_col       <= POS_W'(x_eff);
            r_first_row <= (y_eff == '0);
            r_last_row  <= (y_inc == h_eff);
            r_last_col  <= (x_inc == w_eff);
        end
    end

    // Per-column memory: pixel sum, step sum and the previous row's pixel.
    cmdp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (AW'(r_col)),
        .i_wdata (wr_data),
        .i_re    (i_cmd.accept),
        .i_raddr (AW'(x_eff)),
        .o_rdata (rd_data)
    );

    // Accumulate the column sums; the first row starts them afresh.
    always_comb begin
        rd_mean    = rd_data[MEM_W-1 -: SUM_W];
        rd_detail  = rd_data[PIXEL_BITS +: SUM_W];
        rd_prev    = rd_data[PIXEL_BITS-1:0];
        diff       = (r_pixel >= rd_prev) ? r_pixel - rd_prev : rd_prev - r_pixel;
        new_mean   = r_first_row ? SUM_W'(r_pixel) : rd_mean + SUM_W'(r_pixel);
        new_detail = r_first_row ? '0 : rd_detail + SUM_W'(diff);
        wr_data    = {new_mean, new_detail, r_pixel};
        dividend_mean   = DIV_N'(new_mean) << FRACTION_BITS;
        dividend_detail = DIV_N'(new_detail) << FRACTION_BITS;
    end

    // Mean and detail quotients run side by side.
    cmdp_div #(
        .N     (DIV_N),
        .DVS_W (CFG_W)
    ) u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend_mean),
        .i_divisor  (h_eff),
        .o_busy     (busy_mean),
        .o_quotient (quo_mean)
    );

    cmdp_div #(
        .N     (DIV_N),
        .DVS_W (CFG_W)
    ) u_div_detail (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend_detail),
        .i_divisor  (steps),
        .o_busy     (busy_detail),
        .o_quotient (quo_detail)
    );

    // Result register; it frees up when the held result is taken.
    assign out_free = !r_res_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_column <= COL_W'(r_col);
            r_mean   <= RES_W'(quo_mean);
            r_detail <= RES_W'(quo_detail);
            r_last   <= r_last_col;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.last_row = r_last_row;
        o_status.div_busy = busy_mean || busy_detail;
        o_status.out_free = out_free;
    end

    assign o_res_valid     = r_res_valid;
    assign o_column        = r_column;
    assign o_column_mean   = r_mean;
    assign o_column_detail = r_detail;
    assign o_last_column   = r_last;

endmodule

// File: hdl/column_mean_and_detail_profile_unit.sv
// Top level of the column mean and detail profile unit.
//
// Pixels enter in raster order on the pixel channel (i_pix_valid / o_pix_ready).
// For each column the unit accumulates the pixel sum and the sum of absolute
// vertical steps in one column memory. Every pixel of the last row produces one
// result on the result channel (o_res_valid / i_res_ready): the column index,
// the mean and the detail with FRACTION_BITS fraction bits, and a flag on the
// image's final column. Other pixels produce no result.
// A pixel outside the last row is transferred, then its column is updated by a
// memory read-modify-write before the next pixel is taken. A last-row pixel
// then also starts the two bit-serial dividers that form the mean and the
// detail; no new pixel is taken until both finish and the result is loaded
// into the result register.
// The result register holds a finished result while the receiver stalls, and
// the next pixel may transfer meanwhile; a following result waits for it.
// Geometry writes (i_cfg_we) restart the frame; the user must make them between frames, the block does not enforce it.
// Reset sets both sizes to 1024, the position to the first pixel and clears
// the result register's valid flag; the column memory needs no clearing.
module column_mean_and_detail_profile_unit import cmdp_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PIXEL_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_pix_valid,
    output logic             o_pix_ready,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [COL_W-1:0] o_column,
    output logic [RES_W-1:0] o_column_mean,
    output logic [RES_W-1:0] o_column_detail,
    output logic             o_last_column
);

    t_cmd    cmd;
    t_status status;

    // Sequencing of each pixel.
    cmdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    cmdp_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PIXEL_BITS    (PIXEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .i_res_ready     (i_res_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_res_valid     (o_res_valid),
        .o_column        (o_column),
        .o_column_mean   (o_column_mean),
        .o_column_detail (o_column_detail),
        .o_last_column   (o_last_column)
    );

endmodule

// File: hdl/cmdp_checker.sv
// Port-level checker of the column profile unit and its bind statement.
`include "column_mean_and_detail_profile_unit_macros.svh"

module cmdp_checker import cmdp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0] i_cfg_data,
    input logic             i_pix_valid,
    input logic             o_pix_ready,
    input logic [PIX_W-1:0] i_pixel,
    input logic             o_res_valid,
    input logic             i_res_ready,
    input logic [COL_W-1:0] o_column,
    input logic [RES_W-1:0] o_column_mean,
    input logic [RES_W-1:0] o_column_detail,
    input logic             o_last_column
);

    // A stalled result stays offered.
    `CMDP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid)

    // A stalled result keeps its payload.
    `CMDP_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, o_res_valid && !i_res_ready, $stable(o_column) && $stable(o_column_mean) && $stable(o_column_detail) && $stable(o_last_column))

    // After each pixel transfer the input is closed in the following cycle, for the memory update.
    `CMDP_ASSERT_NEXT(a_pix_gap, i_clk, i_rst_n, i_pix_valid && o_pix_ready, !o_pix_ready)

    // A fresh result always comes with the pixel input open again.
    `CMDP_ASSERT_SAME(a_res_ready_in, i_clk, i_rst_n, $rose(o_res_valid), o_pix_ready)

endmodule

bind column_mean_and_detail_profile_unit cmdp_checker u_checker (.*);
